/* design/pti_pkg.sv */
// Shared types, codes and constants for the photometric table interpolator.
`timescale 1ns / 1ps

package pti_pkg;

  localparam int DEF_MAX_VERTICAL   = 256;
  localparam int DEF_MAX_HORIZONTAL = 64;
  localparam int DEF_ANGLE_BITS     = 16;

  localparam int FRAC_BITS = 16;
  localparam logic [FRAC_BITS:0] ONE_Q16 = 17'h10000;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VCOUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HCOUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE  = 2'd2;

  localparam logic [2:0] CMD_LOAD_V   = 3'd0;
  localparam logic [2:0] CMD_LOAD_H   = 3'd1;
  localparam logic [2:0] CMD_LOAD_C   = 3'd2;
  localparam logic [2:0] CMD_QUERY_2D = 3'd3;
  localparam logic [2:0] CMD_QUERY_1D = 3'd4;
  localparam logic [2:0] CMD_RESTART  = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DEC   = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;
  localparam logic [1:0] STAT_EARLY = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] angle_v;
    logic [15:0] angle_h;
    logic [23:0] candela_raw;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic start;
  } axis_ctl_t;

  typedef struct packed {
    logic       done;
    logic       full;
    logic [1:0] ld_status;
  } axis_res_t;

endpackage

/* design/pti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pti_axis.sv */
// One angle table: loading with order check, binary search and fraction divider.
`timescale 1ns / 1ps

module pti_axis #(
  parameter int DEPTH      = pti_pkg::DEF_MAX_VERTICAL,
  parameter int ANGLE_BITS = pti_pkg::DEF_ANGLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [$clog2(DEPTH+1)-1:0]             cnt,
  input  pti_pkg::axis_ctl_t                     ctl,
  input  logic [ANGLE_BITS-1:0]                  angle,
  output pti_pkg::axis_res_t                     res,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] idx,
  output logic [pti_pkg::FRAC_BITS-1:0]          frac
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AB = ANGLE_BITS;
  localparam int FB = pti_pkg::FRAC_BITS;
  localparam int DCW = $clog2(FB+1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_T0   = 3'd1;
  localparam logic [2:0] A_TN   = 3'd2;
  localparam logic [2:0] A_STEP = 3'd3;
  localparam logic [2:0] A_CMP  = 3'd4;
  localparam logic [2:0] A_NEXT = 3'd5;
  localparam logic [2:0] A_DIV  = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          done_r, done_nxt;
  logic [AB-1:0] last_r, last_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [AB-1:0] tlo_r, tlo_nxt, den_r, den_nxt, rem_r, rem_nxt;
  logic [FB-1:0] quo_r, quo_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;

  logic [AB-1:0] rd_data;
  logic [IW-1:0] raddr;
  logic [IW-1:0] nm1, mid_w, lo_p1;
  logic [IW:0]   mid_sum;
  logic          has_next;
  logic [AB:0]   rem2;
  logic [1:0]    ld_status;
  logic          wr_en;

  assign nm1      = IW'(cnt - CW'(1));
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} + (IW+1)'(1);
  assign mid_w    = mid_sum[IW:1];
  assign lo_p1    = IW'({1'b0, lo_r} + (IW+1)'(1));
  assign has_next = (32'(lo_r) + 32'd1) < 32'(cnt);
  assign rem2     = {rem_r, 1'b0};

  always_comb begin
    if (fill_r >= cnt) begin
      ld_status = pti_pkg::STAT_OVF;
    end else if (fill_r != '0 && angle < last_r) begin
      ld_status = pti_pkg::STAT_DEC;
    end else begin
      ld_status = pti_pkg::STAT_OK;
    end
  end

  assign wr_en = ctl.load && (ld_status == pti_pkg::STAT_OK);

  always_comb begin
    case (st_r)
      A_T0:    raddr = nm1;
      A_STEP:  raddr = (lo_r < hi_r) ? mid_w : lo_p1;
      default: raddr = '0;
    endcase
  end

  pti_ram #(.WIDTH(AB), .DEPTH(DEPTH)) u_tab (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IW'(fill_r)),
    .wdata (angle),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    st_nxt   = st_r;
    fill_nxt = fill_r;
    done_nxt = done_r;
    last_nxt = last_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    tlo_nxt  = tlo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dcnt_nxt = dcnt_r;

    if (ctl.restart) begin
      fill_nxt = '0;
    end else if (wr_en) begin
      fill_nxt = fill_r + CW'(1);
      last_nxt = angle;
    end

    case (st_r)
      A_IDLE: begin
        if (ctl.start) begin
          st_nxt   = A_T0;
          done_nxt = 1'b0;
          quo_nxt  = '0;
        end
      end
      A_T0: begin
        tlo_nxt = rd_data;
        if (angle < rd_data) begin
          // below the first angle: clamp to entry zero
          lo_nxt   = '0;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end else begin
          st_nxt = A_TN;
        end
      end
      A_TN: begin
        if (angle > rd_data) begin
          lo_nxt   = nm1;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end else begin
          lo_nxt = '0;
          hi_nxt = nm1;
          st_nxt = A_STEP;
        end
      end
      A_STEP: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid_w;
          st_nxt  = A_CMP;
        end else if (has_next) begin
          st_nxt = A_NEXT;
        end else begin
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_CMP: begin
        if (angle >= rd_data) begin
          lo_nxt  = mid_r;
          tlo_nxt = rd_data;
        end else begin
          hi_nxt = mid_r - IW'(1);
        end
        st_nxt = A_STEP;
      end
      A_NEXT: begin
        // angle sits strictly below the next entry, so the step is nonzero
        rem_nxt  = angle - tlo_r;
        den_nxt  = rd_data - tlo_r;
        dcnt_nxt = '0;
        st_nxt   = A_DIV;
      end
      A_DIV: begin
        if (rem2 >= {1'b0, den_r}) begin
          rem_nxt = AB'(rem2 - {1'b0, den_r});
          quo_nxt = {quo_r[FB-2:0], 1'b1};
        end else begin
          rem_nxt = AB'(rem2);
          quo_nxt = {quo_r[FB-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(FB-1)) begin
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      fill_r <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    tlo_r  <= tlo_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dcnt_r <= dcnt_nxt;
  end

  assign res.done      = done_r;
  assign res.full      = (fill_r >= cnt);
  assign res.ld_status = ld_status;
  assign idx           = lo_r;
  assign frac          = quo_r;

endmodule

/* design/photometric_table_interpolator_unit.sv */
// Top level: candela grid memory, query sequencer and output register.
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Word
// in_      in   in_valid/in_stall    pti_pkg::in_word_t  (cmd, angles, candela_raw)
// out_     out  out_valid/out_stall  pti_pkg::out_word_t (value, status)
// cfg_     in   cfg_we               cfg_index, cfg_data (counts, scale)
//
// One word at a time; loads, restart and rejected queries pass only T_EXEC and T_DONE.
// A query searches both tables in parallel: end probes, binary search probes and a
// fraction divide. 2D then blends the two neighbouring columns, 1D every column, and
// 1D ends with a restoring divide of the column sum by the column count.
// Synchronous reset empties all tables and sets counts to 1, scale to 1.0.
// A stalled result holds in the output register while the next input word is taken.

module photometric_table_interpolator_unit #(
  parameter int MAX_VERTICAL   = pti_pkg::DEF_MAX_VERTICAL,
  parameter int MAX_HORIZONTAL = pti_pkg::DEF_MAX_HORIZONTAL,
  parameter int ANGLE_BITS     = pti_pkg::DEF_ANGLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pti_pkg::in_word_t                  in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pti_pkg::out_word_t                 out_word,
  input  logic                               cfg_we,
  input  logic [pti_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pti_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int VCW = $clog2(MAX_VERTICAL+1);
  localparam int HCW = $clog2(MAX_HORIZONTAL+1);
  localparam int VIW = (MAX_VERTICAL > 1) ? $clog2(MAX_VERTICAL) : 1;
  localparam int HIW = (MAX_HORIZONTAL > 1) ? $clog2(MAX_HORIZONTAL) : 1;
  localparam int GD  = MAX_VERTICAL * MAX_HORIZONTAL;
  localparam int GAW = (GD > 1) ? $clog2(GD) : 1;
  localparam int GCW = $clog2(GD+1);
  localparam int EW  = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam int FB  = pti_pkg::FRAC_BITS;
  localparam int PW  = 32 + FB;        // one column blend, Q16
  localparam int SW  = PW + HCW;       // sum over all columns
  localparam int DW  = SW - FB;        // 1D dividend after dropping Q16
  localparam int DCW = $clog2(DW+1);

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_EXEC = 4'd1;
  localparam logic [3:0] T_SRCH = 4'd2;
  localparam logic [3:0] T_RLO  = 4'd3;
  localparam logic [3:0] T_RHI  = 4'd4;
  localparam logic [3:0] T_MUL  = 4'd5;
  localparam logic [3:0] T_SUM  = 4'd6;
  localparam logic [3:0] T_WMUL = 4'd7;
  localparam logic [3:0] T_WLO  = 4'd8;
  localparam logic [3:0] T_WHI  = 4'd9;
  localparam logic [3:0] T_ACC  = 4'd10;
  localparam logic [3:0] T_DIV  = 4'd11;
  localparam logic [3:0] T_DONE = 4'd12;

  // configuration
  logic [8:0]  vcnt_r;
  logic [6:0]  hcnt_r;
  logic [15:0] scale_r;

  // control
  logic [3:0]     st_r, st_nxt;
  logic [GCW-1:0] gfill_r, gfill_nxt;
  logic           out_valid_r, out_valid_nxt;

  // datapath
  pti_pkg::in_word_t  in_word_r;
  pti_pkg::out_word_t res_r, res_nxt, out_word_r, out_word_nxt;
  logic           mode1d_r, mode1d_nxt;
  logic           second_r, second_nxt;
  logic [HIW-1:0] col_r, col_nxt;
  logic [31:0]    glo_r, glo_nxt;
  logic [PW:0]    pa_r, pa_nxt, pb_r, pb_nxt;
  logic [PW-1:0]  p_r, p_nxt;
  logic [48:0]    wl_r, wl_nxt;
  logic [32:0]    wh_r, wh_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [DW-1:0]  dq_r, dq_nxt;
  logic [HCW-1:0] drem_r, drem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;

  logic [VCW-1:0] nv;
  logic [HCW-1:0] nh;
  logic [GCW-1:0] gtotal;
  logic [EW-1:0]  av_ext, ah_ext;
  logic [ANGLE_BITS-1:0] av, ah;
  logic [2:0]     cmd;
  logic           is_query, all_full, out_free;

  pti_pkg::axis_ctl_t v_ctl, h_ctl;
  pti_pkg::axis_res_t v_res, h_res;
  logic [VIW-1:0] iy, row1;
  logic [HIW-1:0] ix, ix1, col_cur;
  logic [FB-1:0]  fy, fx;
  logic [FB:0]    wcol;

  logic           g_we;
  logic [GAW-1:0] g_raddr, addr_lo, addr_hi;
  logic [31:0]    g_wdata, g_rdata;
  logic [39:0]    scaled;
  logic [63:0]    acc_hi_sum;
  logic [HCW:0]   drem2;

  // Effective counts: zero acts as one, anything above the table depth clamps.
  always_comb begin
    if (vcnt_r == '0) begin
      nv = VCW'(1);
    end else if (32'(vcnt_r) > 32'(MAX_VERTICAL)) begin
      nv = VCW'(MAX_VERTICAL);
    end else begin
      nv = VCW'(vcnt_r);
    end
    if (hcnt_r == '0) begin
      nh = HCW'(1);
    end else if (32'(hcnt_r) > 32'(MAX_HORIZONTAL)) begin
      nh = HCW'(MAX_HORIZONTAL);
    end else begin
      nh = HCW'(hcnt_r);
    end
  end

  assign gtotal = GCW'(32'(nv) * 32'(nh));

  // Angles use only their low ANGLE_BITS bits.
  assign av_ext = EW'(in_word_r.angle_v);
  assign ah_ext = EW'(in_word_r.angle_h);
  assign av     = av_ext[ANGLE_BITS-1:0];
  assign ah     = ah_ext[ANGLE_BITS-1:0];
  assign cmd    = in_word_r.cmd;

  assign is_query = (cmd == pti_pkg::CMD_QUERY_2D) || (cmd == pti_pkg::CMD_QUERY_1D);
  assign all_full = v_res.full && h_res.full && (gfill_r >= gtotal);

  always_comb begin
    v_ctl.load    = (st_r == T_EXEC) && (cmd == pti_pkg::CMD_LOAD_V);
    v_ctl.restart = (st_r == T_EXEC) && (cmd == pti_pkg::CMD_RESTART);
    v_ctl.start   = (st_r == T_EXEC) && is_query && all_full;
    h_ctl.load    = (st_r == T_EXEC) && (cmd == pti_pkg::CMD_LOAD_H);
    h_ctl.restart = v_ctl.restart;
    h_ctl.start   = v_ctl.start;
  end

  pti_axis #(.DEPTH(MAX_VERTICAL), .ANGLE_BITS(ANGLE_BITS)) u_vaxis (
    .clk   (clk),
    .rst_n (rst_n),
    .cnt   (nv),
    .ctl   (v_ctl),
    .angle (av),
    .res   (v_res),
    .idx   (iy),
    .frac  (fy)
  );

  pti_axis #(.DEPTH(MAX_HORIZONTAL), .ANGLE_BITS(ANGLE_BITS)) u_haxis (
    .clk   (clk),
    .rst_n (rst_n),
    .cnt   (nh),
    .ctl   (h_ctl),
    .angle (ah),
    .res   (h_res),
    .idx   (ix),
    .frac  (fx)
  );

  // Upper neighbors wrap back to entry zero past the last index.
  assign row1 = (32'(iy) + 32'd1 == 32'(nv)) ? '0 : VIW'(32'(iy) + 32'd1);
  assign ix1  = (32'(ix) + 32'd1 == 32'(nh)) ? '0 : HIW'(32'(ix) + 32'd1);

  assign col_cur = mode1d_r ? col_r : (second_r ? ix1 : ix);
  assign wcol    = second_r ? {1'b0, fx} : (pti_pkg::ONE_Q16 - {1'b0, fx});
  assign addr_lo = GAW'(32'(iy) + 32'(nv) * 32'(col_cur));
  assign addr_hi = GAW'(32'(row1) + 32'(nv) * 32'(col_cur));

  assign scaled  = 40'(in_word_r.candela_raw) * 40'(scale_r);
  assign g_wdata = scaled[39:8];
  assign g_we    = (st_r == T_EXEC) && (cmd == pti_pkg::CMD_LOAD_C) && (gfill_r < gtotal);
  assign g_raddr = (st_r == T_RHI) ? addr_hi : addr_lo;

  pti_ram #(.WIDTH(32), .DEPTH(GD)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (GAW'(gfill_r)),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  assign acc_hi_sum = acc_r + {wh_r[31:0], 32'b0};
  assign drem2      = {drem_r, dq_r[DW-1]};
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    st_nxt        = st_r;
    gfill_nxt     = gfill_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    res_nxt       = res_r;
    mode1d_nxt    = mode1d_r;
    second_nxt    = second_r;
    col_nxt       = col_r;
    glo_nxt       = glo_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    p_nxt         = p_r;
    wl_nxt        = wl_r;
    wh_nxt        = wh_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    dcnt_nxt      = dcnt_r;

    case (st_r)
      T_IDLE: begin
        if (in_valid) begin
          st_nxt = T_EXEC;
        end
      end
      T_EXEC: begin
        res_nxt.value  = '0;
        res_nxt.status = pti_pkg::STAT_OK;
        st_nxt         = T_DONE;
        case (cmd)
          pti_pkg::CMD_LOAD_V: res_nxt.status = v_res.ld_status;
          pti_pkg::CMD_LOAD_H: res_nxt.status = h_res.ld_status;
          pti_pkg::CMD_LOAD_C: begin
            if (gfill_r >= gtotal) begin
              res_nxt.status = pti_pkg::STAT_OVF;
            end else begin
              gfill_nxt = gfill_r + GCW'(1);
            end
          end
          pti_pkg::CMD_QUERY_2D, pti_pkg::CMD_QUERY_1D: begin
            if (!all_full) begin
              res_nxt.status = pti_pkg::STAT_EARLY;
            end else begin
              mode1d_nxt = (cmd == pti_pkg::CMD_QUERY_1D);
              second_nxt = 1'b0;
              col_nxt    = '0;
              acc_nxt    = '0;
              sum_nxt    = '0;
              st_nxt     = T_SRCH;
            end
          end
          pti_pkg::CMD_RESTART: gfill_nxt = '0;
          default: ;
        endcase
      end
      T_SRCH: begin
        if (v_res.done && h_res.done) begin
          st_nxt = T_RLO;
        end
      end
      T_RLO: st_nxt = T_RHI;
      T_RHI: begin
        glo_nxt = g_rdata;
        st_nxt  = T_MUL;
      end
      T_MUL: begin
        pa_nxt = (PW+1)'(glo_r) * (PW+1)'(pti_pkg::ONE_Q16 - {1'b0, fy});
        pb_nxt = (PW+1)'(g_rdata) * (PW+1)'(fy);
        st_nxt = T_SUM;
      end
      T_SUM: begin
        p_nxt  = PW'(pa_r + pb_r);
        st_nxt = mode1d_r ? T_ACC : T_WMUL;
      end
      T_ACC: begin
        sum_nxt = sum_r + SW'(p_r);
        if (32'(col_r) + 32'd1 == 32'(nh)) begin
          dq_nxt   = DW'((sum_r + SW'(p_r)) >> FB);
          drem_nxt = '0;
          dcnt_nxt = '0;
          st_nxt   = T_DIV;
        end else begin
          col_nxt = col_r + HIW'(1);
          st_nxt  = T_RLO;
        end
      end
      T_WMUL: begin
        // split the 48-bit blend so each product stays within 32 x 17
        wl_nxt = 49'(p_r[31:0]) * 49'(wcol);
        wh_nxt = 33'(p_r[PW-1:32]) * 33'(wcol);
        st_nxt = T_WLO;
      end
      T_WLO: begin
        acc_nxt = acc_r + 64'(wl_r);
        st_nxt  = T_WHI;
      end
      T_WHI: begin
        acc_nxt = acc_hi_sum;
        if (!second_r) begin
          second_nxt = 1'b1;
          st_nxt     = T_RLO;
        end else begin
          res_nxt.value = acc_hi_sum[63:32];
          st_nxt        = T_DONE;
        end
      end
      T_DIV: begin
        // restoring divide of the column average, one quotient bit a cycle
        if (drem2 >= {1'b0, nh}) begin
          drem_nxt = HCW'(drem2 - {1'b0, nh});
          dq_nxt   = {dq_r[DW-2:0], 1'b1};
        end else begin
          drem_nxt = HCW'(drem2);
          dq_nxt   = {dq_r[DW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(DW-1)) begin
          res_nxt.value = dq_nxt[31:0];
          st_nxt        = T_DONE;
        end
      end
      T_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          st_nxt        = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      gfill_r     <= '0;
      out_valid_r <= 1'b0;
      vcnt_r      <= 9'd1;
      hcnt_r      <= 7'd1;
      scale_r     <= 16'd256;
    end else begin
      st_r        <= st_nxt;
      gfill_r     <= gfill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pti_pkg::CFG_VCOUNT: vcnt_r  <= cfg_data[8:0];
          pti_pkg::CFG_HCOUNT: hcnt_r  <= cfg_data[6:0];
          pti_pkg::CFG_SCALE:  scale_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == T_IDLE && in_valid) begin
      in_word_r <= in_word;
    end
    out_word_r <= out_word_nxt;
    res_r      <= res_nxt;
    mode1d_r   <= mode1d_nxt;
    second_r   <= second_nxt;
    col_r      <= col_nxt;
    glo_r      <= glo_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    p_r        <= p_nxt;
    wl_r       <= wl_nxt;
    wh_r       <= wh_nxt;
    acc_r      <= acc_nxt;
    sum_r      <= sum_nxt;
    dq_r       <= dq_nxt;
    drem_r     <= drem_nxt;
    dcnt_r     <= dcnt_nxt;
  end

  assign in_stall  = (st_r != T_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
